// File: rtl/tcm_pkg.sv
// Shared types and constants of the text console with mouse cursor.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package tcm_pkg;

	// Screen geometry.
	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
	localparam int CELL_AW     = $clog2(CELL_COUNT);

	// Field widths set by the ports.
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int IDX_W  = 11;
	localparam int DATA_W = 16;
	localparam int SUM_W  = 9;

	// Reset place of the mouse cursor.
	localparam int MOUSE_HOME_COL = 40;
	localparam int MOUSE_HOME_ROW = 12;
	localparam int MOUSE_HOME_IDX = MOUSE_HOME_ROW * SCREEN_COLS + MOUSE_HOME_COL;

	// Character and attribute constants.
	localparam logic [7:0] CHAR_NULL    = 8'h00;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] ATTR_DEFAULT = 8'h07;

	// Input operation codes.
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_MOUSE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

	// Classified command kinds.
	typedef logic [2:0] cmd_kind_t;
	localparam cmd_kind_t KIND_NOP     = 3'd0;
	localparam cmd_kind_t KIND_PUT     = 3'd1;
	localparam cmd_kind_t KIND_NEWLINE = 3'd2;
	localparam cmd_kind_t KIND_MOUSE   = 3'd3;
	localparam cmd_kind_t KIND_READ    = 3'd4;

	// One classified command as it travels through the queue.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         char_code;
		logic signed [7:0]  delta_x;
		logic signed [7:0]  delta_y;
		logic [CELL_AW-1:0] cell_index;
	} cmd_t;

	// Cell address of a column and row.
	function automatic logic [CELL_AW-1:0] cell_addr(input logic [COL_W-1:0] col,
		input logic [ROW_W-1:0] row);
		cell_addr = CELL_AW'(row) * CELL_AW'(SCREEN_COLS) + CELL_AW'(col);
	endfunction

	// Swap the foreground and background nibbles of an attribute.
	function automatic logic [7:0] attr_swap(input logic [7:0] attr);
		attr_swap = {attr[3:0], attr[7:4]};
	endfunction

endpackage

`default_nettype wire

// File: rtl/tcm_front.sv
// Front part of the text console: takes input transfers and classifies them.
// Depends on tcm_pkg; feeds tcm_queue.
`default_nettype none

module tcm_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire logic [1:0]          operation,
	input  wire logic [7:0]          char_code,
	input  wire logic signed [7:0]   delta_x,
	input  wire logic signed [7:0]   delta_y,
	input  wire logic [10:0]         cell_index,
	output logic                     push_valid,
	output tcm_pkg::cmd_t            push_cmd,
	input  wire logic                push_ready
);
	import tcm_pkg::*;

	logic      valid_s1;
	cmd_t      cmd_s1;
	cmd_t      cmd_cls;
	logic      take;

	// The held command leaves when the queue has room.
	assign cmd_stall  = valid_s1 && !push_ready;
	assign take       = cmd_valid && !cmd_stall;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	// Sort the operation into the work the back part must do.
	always_comb begin
		cmd_cls.char_code  = char_code;
		cmd_cls.delta_x    = delta_x;
		cmd_cls.delta_y    = delta_y;
		cmd_cls.cell_index = CELL_AW'(cell_index);
		case (operation)
			OP_PUT: begin
				if (char_code == CHAR_NULL)
					cmd_cls.kind = KIND_NOP;
				else if (char_code == CHAR_NEWLINE)
					cmd_cls.kind = KIND_NEWLINE;
				else
					cmd_cls.kind = KIND_PUT;
			end
			OP_MOUSE: cmd_cls.kind = KIND_MOUSE;
			OP_READ: begin
				if (cell_index < IDX_W'(CELL_COUNT))
					cmd_cls.kind = KIND_READ;
				else
					cmd_cls.kind = KIND_NOP;
			end
			default: cmd_cls.kind = KIND_NOP;
		endcase
	end

	// Stage register for one classified command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_cls;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tcm_queue.sv
// Short command queue between the front and back parts of the text console.
// Depends on tcm_pkg.
`default_nettype none

module tcm_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	input  wire tcm_pkg::cmd_t  push_cmd,
	output logic                push_ready,
	output logic                pop_valid,
	output tcm_pkg::cmd_t       pop_cmd,
	input  wire logic           pop
);
	import tcm_pkg::*;

	cmd_t                 slot_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0]  wr_ptr_q;
	logic [QUEUE_PW-1:0]  rd_ptr_q;
	logic [QUEUE_PW:0]    count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = count_q != (QUEUE_PW + 1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tcm_back.sv
// Back part of the text console: cell memories, cursors and the result register.
// Depends on tcm_pkg; takes commands from tcm_queue.
`default_nettype none

module tcm_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_avail,
	input  wire tcm_pkg::cmd_t               cmd,
	output logic                             cmd_pop,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic [tcm_pkg::DATA_W-1:0]       cell_data,
	output logic [tcm_pkg::COL_W-1:0]        text_col,
	output logic [tcm_pkg::ROW_W-1:0]        text_row,
	output logic [tcm_pkg::COL_W-1:0]        mouse_col,
	output logic [tcm_pkg::ROW_W-1:0]        mouse_row,
	output logic                             screen_cleared
);
	import tcm_pkg::*;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_MOLD  = 3'd3;
	localparam logic [2:0] ST_MNEW  = 3'd4;
	localparam logic [2:0] ST_MSWAP = 3'd5;
	localparam logic [2:0] ST_BLANK = 3'd6;

	localparam logic signed [SUM_W-1:0] COL_MAX = SUM_W'(SCREEN_COLS - 1);
	localparam logic signed [SUM_W-1:0] ROW_MAX = SUM_W'(SCREEN_ROWS - 1);

	// Character and attribute bytes live in two memories of their own.
	logic [7:0]          char_mem [CELL_COUNT];
	logic [7:0]          attr_mem [CELL_COUNT];
	logic [7:0]          char_rd_q;
	logic [7:0]          attr_rd_q;

	logic [2:0]          state_q;
	logic [CELL_AW-1:0]  ctr_q;
	cmd_t                cur_q;
	logic [COL_W-1:0]    cur_col_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [COL_W-1:0]    ptr_col_q;
	logic [ROW_W-1:0]    ptr_row_q;
	logic                res_valid_q;
	logic [DATA_W-1:0]   cell_data_q;
	logic                cleared_q;

	logic                char_we;
	logic [CELL_AW-1:0]  char_wa;
	logic [7:0]          char_wd;
	logic                attr_we;
	logic [CELL_AW-1:0]  attr_wa;
	logic [7:0]          attr_wd;
	logic                rd_en;
	logic [CELL_AW-1:0]  rd_addr;

	logic [COL_W:0]      col_inc;
	logic [ROW_W:0]      row_inc;
	logic                ctr_last;
	logic signed [SUM_W-1:0] sum_col;
	logic signed [SUM_W-1:0] sum_row;
	logic [COL_W-1:0]    new_col;
	logic [ROW_W-1:0]    new_row;
	logic                res_take;

	assign res_valid      = res_valid_q;
	assign cell_data      = cell_data_q;
	assign screen_cleared = cleared_q;
	assign text_col       = cur_col_q;
	assign text_row       = cur_row_q;
	assign mouse_col      = ptr_col_q;
	assign mouse_row      = ptr_row_q;
	assign res_take       = res_valid_q && !res_stall;

	// A new command starts only when the result register is empty.
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_avail && !res_valid_q;
	assign col_inc  = {1'b0, cur_col_q} + 1'b1;
	assign row_inc  = {1'b0, cur_row_q} + 1'b1;
	assign ctr_last = ctr_q == CELL_AW'(CELL_COUNT - 1);

	// Wide mouse target, then clamped to the screen.
	assign sum_col = $signed({2'b00, ptr_col_q}) + $signed({cur_q.delta_x[7], cur_q.delta_x});
	assign sum_row = $signed({4'b0000, ptr_row_q}) + $signed({cur_q.delta_y[7], cur_q.delta_y});

	always_comb begin
		if (sum_col < 0)
			new_col = '0;
		else if (sum_col > COL_MAX)
			new_col = COL_MAX[COL_W-1:0];
		else
			new_col = sum_col[COL_W-1:0];
		if (sum_row < 0)
			new_row = '0;
		else if (sum_row > ROW_MAX)
			new_row = ROW_MAX[ROW_W-1:0];
		else
			new_row = sum_row[ROW_W-1:0];
	end

	// Memory port control for each state.
	always_comb begin
		char_we = 1'b0;
		char_wa = cell_addr(cur_col_q, cur_row_q);
		char_wd = cmd.char_code;
		attr_we = 1'b0;
		attr_wa = cell_addr(ptr_col_q, ptr_row_q);
		attr_wd = attr_swap(attr_rd_q);
		rd_en   = 1'b0;
		rd_addr = cell_addr(ptr_col_q, ptr_row_q);
		case (state_q)
			ST_INIT: begin
				char_we = 1'b1;
				char_wa = ctr_q;
				char_wd = CHAR_SPACE;
				attr_we = 1'b1;
				attr_wa = ctr_q;
				attr_wd = (ctr_q == CELL_AW'(MOUSE_HOME_IDX)) ?
					attr_swap(ATTR_DEFAULT) : ATTR_DEFAULT;
			end
			ST_IDLE: begin
				if (cmd_pop) begin
					case (cmd.kind)
						KIND_PUT: char_we = 1'b1;
						KIND_MOUSE: rd_en = 1'b1;
						KIND_READ: begin
							rd_en   = 1'b1;
							rd_addr = cmd.cell_index;
						end
						default: ;
					endcase
				end
			end
			ST_MOLD: attr_we = 1'b1;
			ST_MNEW: rd_en = 1'b1;
			ST_MSWAP: attr_we = 1'b1;
			ST_BLANK: begin
				char_we = 1'b1;
				char_wa = ctr_q;
				char_wd = CHAR_SPACE;
			end
			default: ;
		endcase
	end

	// Cell memories with registered read data.
	always_ff @(posedge clk) begin
		if (char_we) begin
			char_mem[char_wa] <= char_wd;
		end
		if (rd_en) begin
			char_rd_q <= char_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (attr_we) begin
			attr_mem[attr_wa] <= attr_wd;
		end
		if (rd_en) begin
			attr_rd_q <= attr_mem[rd_addr];
		end
	end

	// Sequencer, cursors and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ctr_q       <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			ptr_col_q   <= COL_W'(MOUSE_HOME_COL);
			ptr_row_q   <= ROW_W'(MOUSE_HOME_ROW);
			res_valid_q <= 1'b0;
		end else begin
			if (res_take) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					ctr_q <= ctr_last ? '0 : ctr_q + 1'b1;
					if (ctr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.kind)
							KIND_PUT, KIND_NEWLINE: begin
								if (cmd.kind == KIND_PUT && col_inc != (COL_W + 1)'(SCREEN_COLS)) begin
									cur_col_q   <= col_inc[COL_W-1:0];
									res_valid_q <= 1'b1;
								end else if (row_inc == (ROW_W + 1)'(SCREEN_ROWS)) begin
									cur_col_q <= '0;
									cur_row_q <= '0;
									ctr_q     <= '0;
									state_q   <= ST_BLANK;
								end else begin
									cur_col_q   <= '0;
									cur_row_q   <= row_inc[ROW_W-1:0];
									res_valid_q <= 1'b1;
								end
							end
							KIND_MOUSE: state_q <= ST_MOLD;
							KIND_READ: state_q <= ST_READ;
							default: res_valid_q <= 1'b1;
						endcase
					end
				end
				ST_READ: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_MOLD: begin
					ptr_col_q <= new_col;
					ptr_row_q <= new_row;
					state_q   <= ST_MNEW;
				end
				ST_MNEW: state_q <= ST_MSWAP;
				ST_MSWAP: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_BLANK: begin
					ctr_q <= ctr_last ? '0 : ctr_q + 1'b1;
					if (ctr_last) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result payload and the command being worked on.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q       <= cmd;
			cell_data_q <= '0;
			cleared_q   <= 1'b0;
		end
		if (state_q == ST_READ) begin
			cell_data_q <= {attr_rd_q, char_rd_q};
		end
		if (state_q == ST_BLANK) begin
			cleared_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: rtl/text_console_with_mouse_cursor.sv
// Top level of the text console with mouse cursor: front, queue and back.
// Depends on tcm_pkg, tcm_front, tcm_queue and tcm_back.
//
//   Channel   Valid       Stall       Payload
//   command   cmd_valid   cmd_stall   operation, char_code, delta_x, delta_y, cell_index
//   result    res_valid   res_stall   cell_data, text_col, text_row, mouse_col,
//                                     mouse_row, screen_cleared
//
// A read passes through ST_READ, a mouse move through ST_MOLD, ST_MNEW and ST_MSWAP;
// other commands finish in ST_IDLE of the back part unless they blank the screen.
// A character or newline that runs past the last row blanks the screen: one cell
// per cycle over all 2000 cells, set by the single write port of the character memory.
// After reset a clearing pass over all 2000 cells fills the screen; commands wait.
// The front and a two-entry queue take transfers while the back works or a
// result waits under res_stall.
`default_nettype none

module text_console_with_mouse_cursor (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_stall,
	input  wire logic [1:0]                    operation,
	input  wire logic [7:0]                    char_code,
	input  wire logic signed [7:0]             delta_x,
	input  wire logic signed [7:0]             delta_y,
	input  wire logic [10:0]                   cell_index,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [15:0]                        cell_data,
	output logic [6:0]                         text_col,
	output logic [4:0]                         text_row,
	output logic [6:0]                         mouse_col,
	output logic [4:0]                         mouse_row,
	output logic                               screen_cleared
);
	import tcm_pkg::*;

	logic  push_valid;
	cmd_t  push_cmd;
	logic  push_ready;
	logic  pop_valid;
	cmd_t  pop_cmd;
	logic  pop;

	// Accept and classify.
	tcm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.operation  (operation),
		.char_code  (char_code),
		.delta_x    (delta_x),
		.delta_y    (delta_y),
		.cell_index (cell_index),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	// Decoupling queue.
	tcm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop        (pop)
	);

	// Execute against the cell memories.
	tcm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_avail      (pop_valid),
		.cmd            (pop_cmd),
		.cmd_pop        (pop),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.cell_data      (cell_data),
		.text_col       (text_col),
		.text_row       (text_row),
		.mouse_col      (mouse_col),
		.mouse_row      (mouse_row),
		.screen_cleared (screen_cleared)
	);

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for the text console with mouse cursor: directed and random command
// streams, with every result checked against a behavioral model of the screen.
// Depends on tcm_pkg and the text_console_with_mouse_cursor RTL.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tcm_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES = 16;
	localparam int RANDOM_ITEMS = 1950;
	localparam int QUIET_TAIL_ITEMS = 200;

	// Clock, reset and block ports.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic [1:0] operation = '0;
	logic [7:0] char_code = '0;
	logic signed [7:0] delta_x = '0;
	logic signed [7:0] delta_y = '0;
	logic [10:0] cell_index = '0;
	logic res_stall = 1'b0;
	logic cmd_stall;
	logic res_valid;
	logic [15:0] cell_data;
	logic [6:0] text_col;
	logic [4:0] text_row;
	logic [6:0] mouse_col;
	logic [4:0] mouse_row;
	logic screen_cleared;

	always #4 clk = ~clk;

	text_console_with_mouse_cursor dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.operation(operation), .char_code(char_code),
		.delta_x(delta_x), .delta_y(delta_y), .cell_index(cell_index),
		.res_valid(res_valid), .res_stall(res_stall),
		.cell_data(cell_data), .text_col(text_col), .text_row(text_row),
		.mouse_col(mouse_col), .mouse_row(mouse_row),
		.screen_cleared(screen_cleared)
	);

	// One expected result transfer.
	typedef struct {
		logic [15:0] cell_data;
		logic [6:0]  text_col;
		logic [4:0]  text_row;
		logic [6:0]  mouse_col;
		logic [4:0]  mouse_row;
		logic        cleared;
	} console_out_t;

	console_out_t pending_outputs[$];

	// Shadow copy of the screen and both cursors.
	logic [15:0] shadow_cells [CELL_COUNT];
	int cur_col;
	int cur_row;
	int ptr_col;
	int ptr_row;

	// Bookkeeping.
	int error_count = 0;
	int effective_items = 0;
	int chars_sent = 0;
	int moves_sent = 0;
	int reads_sent = 0;
	int blanks_seen = 0;
	bit sender_idling = 1'b1;
	bit receiver_idling = 1'b1;

	task automatic report_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_error($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// Swap foreground and background nibbles of the attribute at one cell.
	function automatic void swap_attr_at(int col, int row);
		int idx;
		logic [15:0] v;
		idx = row * SCREEN_COLS + col;
		v = shadow_cells[idx];
		shadow_cells[idx] = {v[11:8], v[15:12], v[7:0]};
	endfunction

	function automatic int clamp_to(int v, int hi);
		if (v < 0)
			return 0;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void reset_shadow();
		foreach (shadow_cells[i])
			shadow_cells[i] = {ATTR_DEFAULT, CHAR_SPACE};
		cur_col = 0;
		cur_row = 0;
		ptr_col = MOUSE_HOME_COL;
		ptr_row = MOUSE_HOME_ROW;
		swap_attr_at(ptr_col, ptr_row);
	endfunction

	// Apply one command to the shadow screen and return the result it produces.
	function automatic console_out_t apply_to_screen(logic [1:0] op, logic [7:0] ch,
		logic signed [7:0] dx, logic signed [7:0] dy, logic [10:0] idx);
		console_out_t r;
		r.cell_data = '0;
		r.cleared = 1'b0;
		if (op == OP_PUT && ch != CHAR_NULL) begin
			if (ch == CHAR_NEWLINE) begin
				cur_col = 0;
				cur_row++;
			end else begin
				shadow_cells[cur_row * SCREEN_COLS + cur_col][7:0] = ch;
				cur_col++;
			end
			if (cur_col >= SCREEN_COLS) begin
				cur_col = 0;
				cur_row++;
			end
			// Running off the bottom blanks characters but keeps attributes.
			if (cur_row >= SCREEN_ROWS) begin
				foreach (shadow_cells[i])
					shadow_cells[i][7:0] = CHAR_SPACE;
				cur_col = 0;
				cur_row = 0;
				r.cleared = 1'b1;
			end
		end else if (op == OP_MOUSE) begin
			swap_attr_at(ptr_col, ptr_row);
			ptr_col = clamp_to(ptr_col + int'(dx), SCREEN_COLS - 1);
			ptr_row = clamp_to(ptr_row + int'(dy), SCREEN_ROWS - 1);
			swap_attr_at(ptr_col, ptr_row);
		end else if (op == OP_READ && idx < CELL_COUNT) begin
			r.cell_data = shadow_cells[idx];
		end
		r.text_col = 7'(cur_col);
		r.text_row = 5'(cur_row);
		r.mouse_col = 7'(ptr_col);
		r.mouse_row = 5'(ptr_row);
		return r;
	endfunction

	// Send one command: optional idle burst, then hold it until the transfer.
	task automatic send_command(input logic [1:0] op, input logic [7:0] ch,
		input logic signed [7:0] dx, input logic signed [7:0] dy, input logic [10:0] idx);
		if (sender_idling && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		operation <= op;
		char_code <= ch;
		delta_x <= dx;
		delta_y <= dy;
		cell_index <= idx;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		pending_outputs.push_back(apply_to_screen(op, ch, dx, dy, idx));
		if (op == OP_PUT && ch != CHAR_NULL) begin
			chars_sent++;
			effective_items++;
		end else if (op == OP_MOUSE) begin
			moves_sent++;
			effective_items++;
		end else if (op == OP_READ) begin
			reads_sent++;
			effective_items++;
		end
	endtask

	// Fields that an operation ignores carry random values.
	task automatic put_char(input logic [7:0] ch);
		send_command(OP_PUT, ch, 8'($urandom), 8'($urandom), 11'($urandom));
	endtask

	task automatic move_mouse(input logic signed [7:0] dx, input logic signed [7:0] dy);
		send_command(OP_MOUSE, 8'($urandom), dx, dy, 11'($urandom));
	endtask

	task automatic read_cell(input logic [10:0] idx);
		send_command(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), idx);
	endtask

	// Stop sending until every outstanding result has come back.
	task automatic wait_for_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_outputs.size() != 0);
	endtask

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		console_out_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_outputs.size() == 0) begin
				report_error("result transfer with no command outstanding");
			end else begin
				want = pending_outputs.pop_front();
				check_field("cell_data", cell_data, want.cell_data);
				check_field("text_col", text_col, want.text_col);
				check_field("text_row", text_row, want.text_row);
				check_field("mouse_col", mouse_col, want.mouse_col);
				check_field("mouse_row", mouse_row, want.mouse_row);
				check_field("screen_cleared", screen_cleared, want.cleared);
				if (want.cleared)
					blanks_seen++;
			end
		end
	end

	// Result stall comes in random bursts while the receiver is idling.
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
			res_stall <= 1'b1;
			stall_left = $urandom_range(0, 8);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Watchdog on cycles without any transfer.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d results outstanding.",
					pending_outputs.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Cells right after reset, including the inverted mouse cell.
	task automatic test_reset_contents();
		read_cell(0);
		read_cell(11'(MOUSE_HOME_IDX));
		read_cell(11'(CELL_COUNT - 1));
	endtask

	// Null, ordinary and extreme characters, then a newline and reads of the first cells.
	task automatic test_text_entry();
		put_char(CHAR_NULL);
		put_char(8'h41);
		put_char(8'hFF);
		put_char(8'h01);
		put_char(CHAR_NEWLINE);
		read_cell(0);
		read_cell(1);
		read_cell(2);
	endtask

	// Zero move, clamping on every side and the inverted cells it leaves.
	task automatic test_mouse_moves();
		move_mouse(8'sd0, 8'sd0);
		read_cell(11'(MOUSE_HOME_IDX));
		move_mouse(-8'sd128, -8'sd128);
		read_cell(0);
		read_cell(11'(MOUSE_HOME_IDX));
		move_mouse(8'sd127, 8'sd127);
		read_cell(11'(CELL_COUNT - 1));
		move_mouse(8'sd127, -8'sd128);
		move_mouse(-8'sd128, 8'sd127);
	endtask

	// Unused operation and reads past the end of the screen.
	task automatic test_unused_and_out_of_range();
		send_command(OP_UNUSED, 8'hFF, -8'sd1, -8'sd1, 11'h7FF);
		read_cell(11'(CELL_COUNT));
		read_cell(11'h7FF);
	endtask

	// Newlines past the last row blank the screen; the mouse cell stays inverted.
	task automatic test_screen_blank();
		int rows_left;
		put_char(8'h5A);
		rows_left = SCREEN_ROWS - cur_row;
		repeat (rows_left) put_char(CHAR_NEWLINE);
		read_cell(0);
		read_cell(11'(ptr_row * SCREEN_COLS + ptr_col));
	endtask

	// Mostly printable text with occasional newlines and odd bytes.
	function automatic logic [7:0] random_text_char();
		case ($urandom_range(0, 19))
			0: return CHAR_NEWLINE;
			1: return 8'($urandom);
			default: return 8'($urandom_range(8'h20, 8'h7E));
		endcase
	endfunction

	// Random segments of text, newlines, mouse moves, reads and noise.
	task automatic test_random_traffic();
		int start_count;
		int n;
		start_count = effective_items;
		while (effective_items - start_count < RANDOM_ITEMS) begin
			if (effective_items - start_count >= RANDOM_ITEMS - QUIET_TAIL_ITEMS) begin
				sender_idling = 1'b0;
				receiver_idling = 1'b0;
			end else begin
				sender_idling = ($urandom_range(0, 3) != 0);
				receiver_idling = ($urandom_range(0, 3) != 0);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					n = $urandom_range(1, 100);
					repeat (n) put_char(random_text_char());
				end
				4: begin
					n = $urandom_range(1, 30);
					repeat (n) put_char(CHAR_NEWLINE);
				end
				5, 6: begin
					n = $urandom_range(1, 8);
					repeat (n) begin
						if ($urandom_range(0, 3) == 0)
							move_mouse(8'($urandom), 8'($urandom));
						else
							move_mouse(8'($urandom_range(0, 10) - 5),
								8'($urandom_range(0, 6) - 3));
					end
				end
				7: begin
					n = $urandom_range(1, 10);
					repeat (n) begin
						case ($urandom_range(0, 2))
							0: read_cell(11'(ptr_row * SCREEN_COLS + ptr_col
								+ $urandom_range(0, 2) - 1));
							1: read_cell(11'(cur_row * SCREEN_COLS + cur_col
								- $urandom_range(0, 3)));
							default: read_cell(11'($urandom));
						endcase
					end
				end
				8: begin
					n = $urandom_range(1, 4);
					repeat (n) begin
						if ($urandom_range(0, 1) == 0)
							send_command(OP_UNUSED, 8'($urandom), 8'($urandom),
								8'($urandom), 11'($urandom));
						else
							put_char(CHAR_NULL);
					end
				end
				default: begin
					wait_for_results();
					read_cell(11'($urandom_range(0, CELL_COUNT - 1)));
				end
			endcase
		end
	endtask

	initial begin
		reset_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_text_entry();
		wait_for_results();
		test_mouse_moves();
		test_unused_and_out_of_range();
		wait_for_results();
		test_screen_blank();
		test_random_traffic();

		// Drain and let the block settle before the verdict.
		cmd_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_outputs.size() != 0)
			report_error($sformatf("%0d results never arrived", pending_outputs.size()));

		$display("Ran %0d characters, %0d mouse moves and %0d reads plus ignored commands.",
			chars_sent, moves_sent, reads_sent);
		$display("The screen was blanked %0d times; %0d mismatches were found.",
			blanks_seen, error_count);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
